FILE: src/pbu_pkg.sv
// Shared types, constants and helper functions for the particle bounce update pipeline.
package pbu_pkg;

	// Field widths of the Q16.16 particle record.
	localparam int WORD_W = 32;
	localparam int DT_W = 17;
	localparam int BNC_W = 3;
	localparam int FRAC_W = 16;

	// Velocity times dt: a signed word times a zero-extended dt.
	localparam int PROD_W = WORD_W + DT_W + 1;
	// Shift of 16 for the format plus 1 for the factor one half.
	localparam int STEP_SHIFT = FRAC_W + 1;

	// Bounce gain of 0.4 as an unsigned Q0.16 constant.
	localparam int GAIN_W = 16;
	localparam logic [GAIN_W-1:0] BOUNCE_GAIN = 16'd26214;
	// Negated vertical velocity (33 bits) times the gain as a 17-bit signed value.
	localparam int BPROD_W = WORD_W + GAIN_W + 2;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GRAVITY   = 2'd0,
		CFG_TIME_STEP = 2'd1,
		CFG_ANIMATE   = 2'd2
	} pbu_cfg_idx_t;

	// One particle record as it travels down the pipeline.
	typedef struct packed {
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] vel_x;
		logic [WORD_W-1:0] vel_y;
		logic [WORD_W-1:0] vel_z;
		logic [WORD_W-1:0] floor_y;
		logic [WORD_W-1:0] ceiling_y;
		logic [BNC_W-1:0]  bounces;
		logic [WORD_W-1:0] life;
		logic              falls;
	} pbu_rec_t;

	// Per-beat control flags that ride along with the record.
	typedef struct packed {
		logic live;
		logic expired;
		logic touch;
	} pbu_ctl_t;

	// Saturate a sign-extended sum back to the signed word range.
	function automatic logic [WORD_W-1:0] sat_word(input logic [WORD_W+1:0] x);
		logic [WORD_W-1:0] r;
		if ((x[WORD_W+1] == x[WORD_W]) && (x[WORD_W] == x[WORD_W-1])) begin
			r = x[WORD_W-1:0];
		end else if (x[WORD_W+1]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Floor of a velocity-dt product divided by 2^17, kept as a 33-bit value.
	function automatic logic [WORD_W:0] step_of(input logic [PROD_W-1:0] p);
		return p[PROD_W-1:STEP_SHIFT];
	endfunction

	// Add a 33-bit signed step to a signed word with saturation.
	function automatic logic [WORD_W-1:0] add_step(input logic [WORD_W-1:0] a,
			input logic [WORD_W:0] s);
		logic [WORD_W+1:0] sum;
		sum = {{2{a[WORD_W-1]}}, a} + {s[WORD_W], s};
		return sat_word(sum);
	endfunction

endpackage

FILE: src/particle_bounce_update.sv
// Particle bounce update: four-stage pipeline that advances one particle per beat.
//
// Usage:
//   Input beats carry one particle record (position, velocity, vertical bounds,
//   bounces left, life left, gravity flag) on in_valid / in_stall. Output beats
//   carry the updated record and the expired flag on out_valid / out_stall.
//   A beat moves at a rising edge where valid is high and stall is low.
//   Configuration (gravity, dt, animate enable) is written through cfg_we, cfg_index
//   and cfg_wdata; the user must write only while the pipeline is empty (unenforced).
// Stages and throughput:
//   A beat passes four registered stages in turn: multiply, integrate, clamp with
//   the bounce gain product, and the bounce response in the output register.
//   One record per cycle is accepted while the output is taken every cycle.
// Reset:
//   arst_n clears all stage valid bits and loads the configuration reset values
//   (gravity 0, dt 0, animation enabled). No clearing pass is needed.
// Stalls:
//   Each stage advances when the next one is empty or advancing, so bubbles are
//   squeezed out; in_stall rises only when all four stages hold records.
module particle_bounce_update
	import pbu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] pos_x,
	input  logic [WORD_W-1:0] pos_y,
	input  logic [WORD_W-1:0] pos_z,
	input  logic [WORD_W-1:0] vel_x,
	input  logic [WORD_W-1:0] vel_y,
	input  logic [WORD_W-1:0] vel_z,
	input  logic [WORD_W-1:0] floor_y,
	input  logic [WORD_W-1:0] ceiling_y,
	input  logic [BNC_W-1:0]  bounces_in,
	input  logic [WORD_W-1:0] life_in,
	input  logic              falls,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] new_pos_x,
	output logic [WORD_W-1:0] new_pos_y,
	output logic [WORD_W-1:0] new_pos_z,
	output logic [WORD_W-1:0] new_vel_x,
	output logic [WORD_W-1:0] new_vel_y,
	output logic [WORD_W-1:0] new_vel_z,
	output logic [BNC_W-1:0]  bounces_out,
	output logic [WORD_W-1:0] life_out,
	output logic              expired
);

	logic [WORD_W-1:0]  gravity_q;
	logic [DT_W-1:0]    dt_q;
	logic               animate_q;

	pbu_rec_t           rec_in;
	logic               adv1, adv2, adv3, adv4;
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	pbu_rec_t           rec_s1, rec_s2, rec_s3, rec_s4;
	pbu_ctl_t           ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [PROD_W-1:0]  prod_x_s1, prod_y_s1, prod_z_s1, prod_g_s1;
	logic [BPROD_W-1:0] bprod_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= '0;
			dt_q <= '0;
			animate_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRAVITY:   gravity_q <= cfg_wdata;
				CFG_TIME_STEP: dt_q <= cfg_wdata[DT_W-1:0];
				CFG_ANIMATE:   animate_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Gather the input fields into one record.
	always_comb begin
		rec_in.pos_x = pos_x;
		rec_in.pos_y = pos_y;
		rec_in.pos_z = pos_z;
		rec_in.vel_x = vel_x;
		rec_in.vel_y = vel_y;
		rec_in.vel_z = vel_z;
		rec_in.floor_y = floor_y;
		rec_in.ceiling_y = ceiling_y;
		rec_in.bounces = bounces_in;
		rec_in.life = life_in;
		rec_in.falls = falls;
	end

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		adv4 = !valid_s4 || !out_stall;
		adv3 = !valid_s3 || adv4;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
		in_stall = !adv1;
	end

	pbu_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv1),
		.valid_in  (in_valid),
		.rec_in    (rec_in),
		.gravity   (gravity_q),
		.dt        (dt_q),
		.animate   (animate_q),
		.valid_s1  (valid_s1),
		.rec_s1    (rec_s1),
		.ctl_s1    (ctl_s1),
		.prod_x_s1 (prod_x_s1),
		.prod_y_s1 (prod_y_s1),
		.prod_z_s1 (prod_z_s1),
		.prod_g_s1 (prod_g_s1)
	);

	pbu_integrate u_integrate (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv2),
		.valid_s1  (valid_s1),
		.rec_s1    (rec_s1),
		.ctl_s1    (ctl_s1),
		.prod_x_s1 (prod_x_s1),
		.prod_y_s1 (prod_y_s1),
		.prod_z_s1 (prod_z_s1),
		.prod_g_s1 (prod_g_s1),
		.dt        (dt_q),
		.valid_s2  (valid_s2),
		.rec_s2    (rec_s2),
		.ctl_s2    (ctl_s2)
	);

	pbu_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv3),
		.valid_s2 (valid_s2),
		.rec_s2   (rec_s2),
		.ctl_s2   (ctl_s2),
		.valid_s3 (valid_s3),
		.rec_s3   (rec_s3),
		.ctl_s3   (ctl_s3),
		.bprod_s3 (bprod_s3)
	);

	pbu_bounce u_bounce (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv4),
		.valid_s3 (valid_s3),
		.rec_s3   (rec_s3),
		.ctl_s3   (ctl_s3),
		.bprod_s3 (bprod_s3),
		.valid_s4 (valid_s4),
		.rec_s4   (rec_s4),
		.ctl_s4   (ctl_s4)
	);

	// Output beat straight from the last stage register.
	always_comb begin
		out_valid = valid_s4;
		new_pos_x = rec_s4.pos_x;
		new_pos_y = rec_s4.pos_y;
		new_pos_z = rec_s4.pos_z;
		new_vel_x = rec_s4.vel_x;
		new_vel_y = rec_s4.vel_y;
		new_vel_z = rec_s4.vel_z;
		bounces_out = rec_s4.bounces;
		life_out = rec_s4.life;
		expired = ctl_s4.expired;
	end

endmodule

FILE: src/pbu_mul.sv
// First stage: velocity and gravity times dt, plus the expiry decision.
module pbu_mul
	import pbu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_in,
	input  pbu_rec_t          rec_in,
	input  logic [WORD_W-1:0] gravity,
	input  logic [DT_W-1:0]   dt,
	input  logic              animate,
	output logic              valid_s1,
	output pbu_rec_t          rec_s1,
	output pbu_ctl_t          ctl_s1,
	output logic [PROD_W-1:0] prod_x_s1,
	output logic [PROD_W-1:0] prod_y_s1,
	output logic [PROD_W-1:0] prod_z_s1,
	output logic [PROD_W-1:0] prod_g_s1
);

	logic signed [DT_W:0]   dt_sx;
	logic signed [PROD_W-1:0] px, py, pz, pg;
	pbu_ctl_t               ctl_d;

	// Four signed products, each registered before use.
	always_comb begin
		dt_sx = $signed({1'b0, dt});
		px = $signed(rec_in.vel_x) * dt_sx;
		py = $signed(rec_in.vel_y) * dt_sx;
		pz = $signed(rec_in.vel_z) * dt_sx;
		pg = $signed(gravity) * dt_sx;
	end

	// A record with life at or below zero is expired and passes unchanged.
	always_comb begin
		ctl_d.expired = rec_in.life[WORD_W-1] || (rec_in.life == '0);
		ctl_d.live = !ctl_d.expired && animate;
		ctl_d.touch = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1 <= rec_in;
			ctl_s1 <= ctl_d;
			prod_x_s1 <= px;
			prod_y_s1 <= py;
			prod_z_s1 <= pz;
			prod_g_s1 <= pg;
		end
	end

endmodule

FILE: src/pbu_integrate.sv
// Second stage: position advance, gravity on vertical velocity, life countdown.
module pbu_integrate
	import pbu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_s1,
	input  pbu_rec_t          rec_s1,
	input  pbu_ctl_t          ctl_s1,
	input  logic [PROD_W-1:0] prod_x_s1,
	input  logic [PROD_W-1:0] prod_y_s1,
	input  logic [PROD_W-1:0] prod_z_s1,
	input  logic [PROD_W-1:0] prod_g_s1,
	input  logic [DT_W-1:0]   dt,
	output logic              valid_s2,
	output pbu_rec_t          rec_s2,
	output pbu_ctl_t          ctl_s2
);

	pbu_rec_t rec_d;

	// Saturating adds on the live record; others pass through untouched.
	always_comb begin
		rec_d = rec_s1;
		if (ctl_s1.live) begin
			rec_d.pos_x = add_step(rec_s1.pos_x, step_of(prod_x_s1));
			rec_d.pos_y = add_step(rec_s1.pos_y, step_of(prod_y_s1));
			rec_d.pos_z = add_step(rec_s1.pos_z, step_of(prod_z_s1));
			if (rec_s1.falls) begin
				rec_d.vel_y = add_step(rec_s1.vel_y, step_of(prod_g_s1));
			end
			rec_d.life = rec_s1.life - {{(WORD_W-DT_W){1'b0}}, dt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s2 <= rec_d;
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

FILE: src/pbu_clamp.sv
// Third stage: height clamp, bound contact and the bounce gain product.
module pbu_clamp
	import pbu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_s2,
	input  pbu_rec_t           rec_s2,
	input  pbu_ctl_t           ctl_s2,
	output logic               valid_s3,
	output pbu_rec_t           rec_s3,
	output pbu_ctl_t           ctl_s3,
	output logic [BPROD_W-1:0] bprod_s3
);

	pbu_rec_t                   rec_d;
	pbu_ctl_t                   ctl_d;
	logic [WORD_W-1:0]          y_lo;
	logic [WORD_W-1:0]          y_cl;
	logic [WORD_W:0]            neg_vy;
	logic signed [BPROD_W-1:0]  bprod;

	// Clamp to the floor first, then to the ceiling so the ceiling wins.
	always_comb begin
		y_lo = ($signed(rec_s2.pos_y) < $signed(rec_s2.floor_y)) ? rec_s2.floor_y
			: rec_s2.pos_y;
		y_cl = ($signed(y_lo) > $signed(rec_s2.ceiling_y)) ? rec_s2.ceiling_y : y_lo;
		rec_d = rec_s2;
		ctl_d = ctl_s2;
		if (ctl_s2.live) begin
			rec_d.pos_y = y_cl;
			ctl_d.touch = (y_cl == rec_s2.floor_y) || (y_cl == rec_s2.ceiling_y);
		end
	end

	// Negated vertical velocity times 0.4; the negation needs a 33rd bit.
	always_comb begin
		neg_vy = -{rec_s2.vel_y[WORD_W-1], rec_s2.vel_y};
		bprod = $signed(neg_vy) * $signed({1'b0, BOUNCE_GAIN});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s3 <= rec_d;
			ctl_s3 <= ctl_d;
			bprod_s3 <= bprod;
		end
	end

endmodule

FILE: src/pbu_bounce.sv
// Fourth stage: bounce or stop response, held in the output register.
module pbu_bounce
	import pbu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_s3,
	input  pbu_rec_t           rec_s3,
	input  pbu_ctl_t           ctl_s3,
	input  logic [BPROD_W-1:0] bprod_s3,
	output logic               valid_s4,
	output pbu_rec_t           rec_s4,
	output pbu_ctl_t           ctl_s4
);

	pbu_rec_t rec_d;

	// On a bound contact, with bounces left the particle rebounds; without, it stops sideways.
	always_comb begin
		rec_d = rec_s3;
		if (ctl_s3.touch) begin
			if (rec_s3.bounces != '0) begin
				rec_d.vel_y = bprod_s3[FRAC_W+WORD_W-1:FRAC_W];
				rec_d.vel_x = {rec_s3.vel_x[WORD_W-1], rec_s3.vel_x[WORD_W-1:1]};
				rec_d.vel_z = {rec_s3.vel_z[WORD_W-1], rec_s3.vel_z[WORD_W-1:1]};
				rec_d.bounces = rec_s3.bounces - BNC_W'(1);
			end else begin
				rec_d.vel_x = '0;
				rec_d.vel_z = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s4 <= rec_d;
			ctl_s4 <= ctl_s3;
		end
	end

endmodule

FILE: src/pbu_checker.sv
// Port-level checks for the particle bounce update block, bound to the top level.
module pbu_checker
	import pbu_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] new_pos_y,
	input logic [WORD_W-1:0] life_out,
	input logic              expired
);

	// Nothing comes out in the cycle reset is released.
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// An empty output stage means every stage can move, so input is never held.
	assert property (@(posedge clk) disable iff (!arst_n) !out_valid |-> !in_stall)
		else $error("input stalled while the output stage is empty");

	// An expired record keeps its life, which is at or below zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> (life_out[WORD_W-1] || (life_out == '0)))
		else $error("expired record with positive life");

	// A stalled output beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_pos_y) && $stable(life_out)
			&& $stable(expired))
		else $error("stalled output beat changed");

endmodule

bind particle_bounce_update pbu_checker u_pbu_checker (.*);

FILE: dv/particle_bounce_update_check.sv
// Checker for the particle bounce update block: channel monitor, frame predictor and comparison.
module particle_bounce_update_check
	import pbu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [WORD_W-1:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [WORD_W-1:0] pos_x,
	input  logic [WORD_W-1:0] pos_y,
	input  logic [WORD_W-1:0] pos_z,
	input  logic [WORD_W-1:0] vel_x,
	input  logic [WORD_W-1:0] vel_y,
	input  logic [WORD_W-1:0] vel_z,
	input  logic [WORD_W-1:0] floor_y,
	input  logic [WORD_W-1:0] ceiling_y,
	input  logic [BNC_W-1:0]  bounces_in,
	input  logic [WORD_W-1:0] life_in,
	input  logic              falls,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [WORD_W-1:0] new_pos_x,
	input  logic [WORD_W-1:0] new_pos_y,
	input  logic [WORD_W-1:0] new_pos_z,
	input  logic [WORD_W-1:0] new_vel_x,
	input  logic [WORD_W-1:0] new_vel_y,
	input  logic [WORD_W-1:0] new_vel_z,
	input  logic [BNC_W-1:0]  bounces_out,
	input  logic [WORD_W-1:0] life_out,
	input  logic              expired,
	output int                fail_count,
	output int                in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	// One updated particle as it should leave the block.
	typedef struct packed {
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] vel_x;
		logic [WORD_W-1:0] vel_y;
		logic [WORD_W-1:0] vel_z;
		logic [BNC_W-1:0]  bounces;
		logic [WORD_W-1:0] life;
		logic              expired;
	} frame_result_t;

	// Shadow copy of the configuration registers.
	longint            gravity_q;
	logic [DT_W-1:0]   dt_q;
	logic              animate_q;

	frame_result_t due_frames[$];
	int                reported;

	// Half of v*dt in Q16.16, floored.
	function automatic longint half_advance(input longint v, input longint dt);
		return (v * dt) >>> STEP_SHIFT;
	endfunction

	function automatic longint clip_word(input longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// Advance one particle record by one frame under the current settings.
	function automatic frame_result_t advance_particle(input pbu_rec_t p);
		frame_result_t r;
		longint px, py, pz, vx, vy, vz, lo, hi, life, dt, gain;
		logic [BNC_W-1:0] bnc_left;
		px = $signed(p.pos_x);
		py = $signed(p.pos_y);
		pz = $signed(p.pos_z);
		vx = $signed(p.vel_x);
		vy = $signed(p.vel_y);
		vz = $signed(p.vel_z);
		lo = $signed(p.floor_y);
		hi = $signed(p.ceiling_y);
		life = $signed(p.life);
		bnc_left = p.bounces;
		dt = dt_q;
		gain = BOUNCE_GAIN;
		r.expired = 1'b0;
		if (life <= 0) begin
			r.expired = 1'b1;
		end else if (animate_q) begin
			// Positions move with the velocity from before this frame.
			py = clip_word(py + half_advance(vy, dt));
			px = clip_word(px + half_advance(vx, dt));
			pz = clip_word(pz + half_advance(vz, dt));
			if (p.falls) begin
				vy = clip_word(vy + half_advance(gravity_q, dt));
			end
			// The ceiling is applied last, so it wins when the bounds cross.
			if (py < lo) begin
				py = lo;
			end
			if (py > hi) begin
				py = hi;
			end
			if (py == lo || py == hi) begin
				if (bnc_left != 0) begin
					vy = ((-vy) * gain) >>> FRAC_W;
					vx = vx >>> 1;
					vz = vz >>> 1;
					bnc_left = bnc_left - 1'b1;
				end else begin
					vx = 0;
					vz = 0;
				end
			end
			life = life - dt;
		end
		r.pos_x = px[WORD_W-1:0];
		r.pos_y = py[WORD_W-1:0];
		r.pos_z = pz[WORD_W-1:0];
		r.vel_x = vx[WORD_W-1:0];
		r.vel_y = vy[WORD_W-1:0];
		r.vel_z = vz[WORD_W-1:0];
		r.bounces = bnc_left;
		r.life = life[WORD_W-1:0];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (reported < 10) begin
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
			end
			reported++;
		end
	endfunction

	// Watch both channels and the register port on every rising edge.
	always @(posedge clk or negedge arst_n) begin : watch
		frame_result_t want;
		if (!arst_n) begin
			gravity_q = 0;
			dt_q = '0;
			animate_q = 1'b1;
			due_frames.delete();
			in_flight = 0;
			fail_count = 0;
			reported = 0;
		end else begin
			// Compare a result beat with the oldest prediction.
			if (out_valid && !out_stall) begin
				if (due_frames.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						$display("%0t: result beat with no particle outstanding", $realtime);
					end
					reported++;
				end else begin
					want = due_frames.pop_front();
					check_field("new_pos_x", want.pos_x, new_pos_x);
					check_field("new_pos_y", want.pos_y, new_pos_y);
					check_field("new_pos_z", want.pos_z, new_pos_z);
					check_field("new_vel_x", want.vel_x, new_vel_x);
					check_field("new_vel_y", want.vel_y, new_vel_y);
					check_field("new_vel_z", want.vel_z, new_vel_z);
					check_field("bounces_out", want.bounces, bounces_out);
					check_field("life_out", want.life, life_out);
					check_field("expired", want.expired, expired);
				end
			end
			// Predict each accepted particle beat and queue it at the tail.
			if (in_valid && !in_stall) begin
				due_frames.insert(due_frames.size(), advance_particle({pos_x, pos_y, pos_z,
					vel_x, vel_y, vel_z, floor_y, ceiling_y, bounces_in, life_in, falls}));
			end
			// Track register writes.
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRAVITY: begin
						gravity_q = $signed(cfg_wdata);
					end
					CFG_TIME_STEP: begin
						dt_q = cfg_wdata[DT_W-1:0];
					end
					CFG_ANIMATE: begin
						animate_q = cfg_wdata[0];
					end
					default: ;
				endcase
			end
			in_flight = due_frames.size();
		end
	end

endmodule

FILE: dv/particle_bounce_update_test.sv
// Testbench top for the particle bounce update block: clock, reset, stimulus and verdict.
module particle_bounce_update_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pbu_pkg::*;

	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;

	// Q16.16 constants for the directed part.
	localparam logic [WORD_W-1:0] ONE = 32'h0001_0000;
	localparam logic [WORD_W-1:0] EARTH_PULL = -32'sd642253;
	localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [DT_W-1:0] FRAME_DT = 17'd1092;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [WORD_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic [WORD_W-1:0] pos_x, pos_y, pos_z;
	logic [WORD_W-1:0] vel_x, vel_y, vel_z;
	logic [WORD_W-1:0] floor_y, ceiling_y;
	logic [BNC_W-1:0]  bounces_in;
	logic [WORD_W-1:0] life_in;
	logic              falls;
	logic              out_valid;
	logic              out_stall;
	logic [WORD_W-1:0] new_pos_x, new_pos_y, new_pos_z;
	logic [WORD_W-1:0] new_vel_x, new_vel_y, new_vel_z;
	logic [BNC_W-1:0]  bounces_out;
	logic [WORD_W-1:0] life_out;
	logic              expired;
	int                fail_count;
	int                in_flight;
	int                quiet_cycles;
	bit                idle_on;
	bit                hold_req;

	particle_bounce_update uut (.*);
	particle_bounce_update_check checker_i (.*);

	always #4ns clk = ~clk;

	// Watchdog: end the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold when asked.
	initial begin
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Signed random value in about plus or minus 2^span.
	function automatic logic [WORD_W-1:0] small_word(input int span);
		return $urandom_range(0, (1 << (span + 1)) - 1) - (1 << span);
	endfunction

	// A plain falling particle well inside its bounds.
	function automatic pbu_rec_t calm_particle();
		pbu_rec_t p;
		p.pos_x = ONE;
		p.pos_y = 5 * ONE;
		p.pos_z = -2 * ONE;
		p.vel_x = ONE / 2;
		p.vel_y = -ONE;
		p.vel_z = ONE / 4;
		p.floor_y = '0;
		p.ceiling_y = 100 * ONE;
		p.bounces = 3'd3;
		p.life = 2 * ONE;
		p.falls = 1'b1;
		return p;
	endfunction

	// Mostly plausible particles near their bounds, some fully random records.
	function automatic pbu_rec_t spawn_particle();
		pbu_rec_t p;
		if ($urandom_range(0, 7) == 0) begin
			p.pos_x = pick_word();
			p.pos_y = pick_word();
			p.pos_z = pick_word();
			p.vel_x = pick_word();
			p.vel_y = pick_word();
			p.vel_z = pick_word();
			p.floor_y = pick_word();
			p.ceiling_y = pick_word();
			p.life = pick_word();
		end else begin
			p.pos_x = small_word(22);
			p.pos_y = small_word(20);
			p.pos_z = small_word(22);
			p.vel_x = small_word(21);
			p.vel_y = small_word(21);
			p.vel_z = small_word(21);
			p.floor_y = p.pos_y - ($urandom_range(0, 1 << 19) - ONE);
			p.ceiling_y = p.pos_y + ($urandom_range(0, 1 << 19) - ONE);
			case ($urandom_range(0, 15))
				0: p.ceiling_y = p.floor_y - $urandom_range(0, 1 << 18);
				1: p.pos_y = p.floor_y;
				2: p.floor_y = p.ceiling_y;
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: p.life = '0;
				1: p.life = WORD_MIN | $urandom();
				2: p.life = WORD_MAX;
				default: p.life = $urandom_range(1, 1 << 20);
			endcase
		end
		p.bounces = ($urandom_range(0, 3) == 0) ? '0 : BNC_W'($urandom_range(1, 7));
		p.falls = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// Offer one particle beat and hold it until the block takes it.
	task automatic offer_particle(input pbu_rec_t p);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		pos_x <= p.pos_x;
		pos_y <= p.pos_y;
		pos_z <= p.pos_z;
		vel_x <= p.vel_x;
		vel_y <= p.vel_y;
		vel_z <= p.vel_z;
		floor_y <= p.floor_y;
		ceiling_y <= p.ceiling_y;
		bounces_in <= p.bounces;
		life_in <= p.life;
		falls <= p.falls;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Let the pipeline drain, then write all three registers back to back.
	task automatic apply_config(input logic [WORD_W-1:0] pull, input logic [DT_W-1:0] dt,
			input logic anim);
		in_valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRAVITY;
		cfg_wdata <= pull;
		@(negedge clk);
		cfg_index <= CFG_TIME_STEP;
		cfg_wdata <= WORD_W'(dt);
		@(negedge clk);
		cfg_index <= CFG_ANIMATE;
		cfg_wdata <= WORD_W'(anim);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		pbu_rec_t p;
		logic [DT_W-1:0] dt;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GRAVITY;
		cfg_wdata = '0;
		in_valid = 1'b0;
		{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, floor_y, ceiling_y, bounces_in,
			life_in, falls} = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero dt and gravity, so only touching a bound changes things.
		p = calm_particle();
		offer_particle(p);
		p.pos_y = p.floor_y;
		offer_particle(p);

		// Ordinary frame settings: expiry, bounces at both bounds and crossed bounds.
		apply_config(EARTH_PULL, FRAME_DT, 1'b1);
		offer_particle(calm_particle());
		p = calm_particle();
		p.life = '0;
		offer_particle(p);
		p.life = WORD_MIN;
		offer_particle(p);
		p.life = 32'd1;
		offer_particle(p);
		p = calm_particle();
		p.pos_y = -ONE;
		offer_particle(p);
		p = calm_particle();
		p.pos_y = 200 * ONE;
		p.bounces = 3'd7;
		offer_particle(p);
		p = calm_particle();
		p.pos_y = -ONE;
		p.bounces = '0;
		offer_particle(p);
		p = calm_particle();
		p.floor_y = 10 * ONE;
		p.ceiling_y = 5 * ONE;
		offer_particle(p);
		p.falls = 1'b0;
		offer_particle(p);
		p = calm_particle();
		p.vel_y = WORD_MIN;
		offer_particle(p);

		// Largest dt and strongest downward gravity: saturation at both ends.
		apply_config(WORD_MIN, '1, 1'b1);
		p = calm_particle();
		p.pos_x = WORD_MAX;
		p.pos_y = WORD_MAX;
		p.pos_z = WORD_MAX;
		p.vel_x = WORD_MAX;
		p.vel_y = WORD_MAX;
		p.vel_z = WORD_MAX;
		p.floor_y = WORD_MIN;
		p.ceiling_y = WORD_MAX;
		p.life = WORD_MAX;
		offer_particle(p);
		p.pos_x = WORD_MIN;
		p.pos_y = WORD_MIN;
		p.pos_z = WORD_MIN;
		p.vel_x = WORD_MIN;
		p.vel_y = WORD_MIN;
		p.vel_z = WORD_MIN;
		offer_particle(p);
		p = calm_particle();
		p.vel_y = '1;
		p.vel_x = '1;
		p.vel_z = '1;
		p.pos_y = '0;
		offer_particle(p);

		// Animation off: live particles pass unchanged, expired ones are flagged.
		apply_config(WORD_MAX, 17'd65536, 1'b0);
		offer_particle(calm_particle());
		p = calm_particle();
		p.life = -ONE;
		offer_particle(p);
		p = calm_particle();
		p.pos_y = -ONE;
		offer_particle(p);

		// Random phases, each under its own settings.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			dt = ($urandom_range(0, 1) == 0) ? DT_W'($urandom_range(1, 4096))
				: DT_W'($urandom_range(0, 65536));
			case (phase)
				0: apply_config(WORD_MAX, 17'd65536, 1'b1);
				3: apply_config(WORD_MIN, '0, 1'b1);
				5: apply_config(pick_word(), dt, 1'b0);
				default: apply_config(small_word(21), dt, 1'b1);
			endcase
			// Hold the result side off long enough to back the pipeline up.
			if (phase == 1) begin
				hold_req = 1'b1;
			end
			// No idling on either side in the last phase.
			if (phase == RANDOM_PHASES - 1) begin
				idle_on = 1'b0;
			end
			repeat (PHASE_ITEMS) offer_particle(spawn_particle());
		end

		in_valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
